// ===== hw/rtl/paik_pkg.sv =====
// Shared constants, widths and the sine table builder for the planar arm IK step core.
`timescale 1ns / 1ps
`default_nettype none
package paik_pkg;

	// Default sizing. The angle resolution must be a power of two.
	localparam int JOINTS_DEF      = 4;
	localparam int ANGLE_STEPS_DEF = 512;
	localparam int LINKS           = 4;

	// Port widths.
	localparam int TARGET_W    = 12;
	localparam int TIP_W       = 19;
	localparam int ANGLE_OUT_W = 9;
	localparam int JOINT_OUT_W = 2;
	localparam int LINK_W      = 8;
	localparam int SETTLE_W    = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// Internal arithmetic widths.
	localparam int FRAC_W      = 8;
	localparam int TARGET_FP_W = TARGET_W + FRAC_W;
	localparam int MAG_W       = 15;
	localparam int TRIG_W      = MAG_W + 1;
	localparam int MUL_W       = 21;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int ACC_W       = 26;
	localparam int DIST_W      = PROD_W;
	localparam int ROUND_SHIFT = 6;
	localparam int ROUND_BIAS  = 32;
	localparam int TIP_MAX     = 262143;
	localparam int TIP_MIN     = -262144;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LINK0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK3  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd4;

	// Register reset values.
	localparam logic [LINK_W-1:0]   LINK0_RST  = 8'd50;
	localparam logic [LINK_W-1:0]   LINK1_RST  = 8'd70;
	localparam logic [LINK_W-1:0]   LINK2_RST  = 8'd30;
	localparam logic [LINK_W-1:0]   LINK3_RST  = 8'd15;
	localparam logic [SETTLE_W-1:0] SETTLE_RST = 16'd512;

	// Q30 odd polynomial for sine over one quadrant.
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint C1      = 64'sd1686629713;
	localparam longint C3      = -64'sd693598669;
	localparam longint C5      = 64'sd85569306;
	localparam longint C7      = -64'sd5026995;
	localparam longint C9      = 64'sd172272;
	localparam longint C11     = -64'sd3864;
	localparam longint MAG_ONE = 64'sd16384;
	localparam longint HALF_LSB = 64'sd32768;
	localparam longint LSB_DIV  = 64'sd65536;

	// Q14 sine magnitude at quadrant step m, with 2**angle_w steps per turn.
	// Evaluated at elaboration only, to fill the quarter-wave table.
	function automatic logic [MAG_W-1:0] quarter_sine(input int m, input int angle_w);
		longint t;
		longint t2;
		longint acc;
		longint v;
		longint mag;
		t   = longint'(m) << (32 - angle_w);
		t2  = (t * t) / Q30_ONE;
		acc = C11;
		acc = C9 + (acc * t2) / Q30_ONE;
		acc = C7 + (acc * t2) / Q30_ONE;
		acc = C5 + (acc * t2) / Q30_ONE;
		acc = C3 + (acc * t2) / Q30_ONE;
		acc = C1 + (acc * t2) / Q30_ONE;
		v   = (acc * t) / Q30_ONE;
		mag = (v > 0) ? (v + HALF_LSB) / LSB_DIV : 64'sd0;
		if (mag > MAG_ONE) begin
			mag = MAG_ONE;
		end
		return MAG_W'(mag);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/planar_arm_ik_coordinate_step_core.sv =====
// Planar arm inverse kinematics: one coordinate descent step per input transfer.
//
// Input channel (in_valid / in_stall): one transfer per update tick carrying the target
// point in whole pixels and a restart flag that points the active joint back at the last
// joint. Output channel (out_valid / out_stall): one result transfer per tick with the tip
// position (8 fraction bits), all joint angles, whether a joint moved and the joint that
// the next tick will adjust. The cfg channel writes link lengths and the settle distance;
// cfg_ready is always high, and writes belong to idle periods.
// All arithmetic runs through one shared multiplier with a two-stage pipeline, fed one
// product per cycle by a small sequencer. A settled tick runs one forward kinematics
// pass; a tick that moves a joint runs three passes. in_stall is high from the input
// transfer until the result has been written to the output register. The output
// register lets the next tick start while a result waits; if the receiver stalls for
// longer than a whole tick, the sequencer holds its next result until the output
// register frees up. Reset restores the link lengths and settle distance, zeroes all
// angles, points at the last joint and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module planar_arm_ik_coordinate_step_core #(
	parameter int JOINTS      = paik_pkg::JOINTS_DEF,
	parameter int ANGLE_STEPS = paik_pkg::ANGLE_STEPS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [paik_pkg::TARGET_W-1:0]  target_x,
	input  wire logic signed [paik_pkg::TARGET_W-1:0]  target_y,
	input  wire logic                                  restart,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [paik_pkg::TIP_W-1:0]          tip_x,
	output logic signed [paik_pkg::TIP_W-1:0]          tip_y,
	output logic [paik_pkg::ANGLE_OUT_W-1:0]           angle_first,
	output logic [paik_pkg::ANGLE_OUT_W-1:0]           angle_second,
	output logic [paik_pkg::ANGLE_OUT_W-1:0]           angle_third,
	output logic [paik_pkg::ANGLE_OUT_W-1:0]           angle_fourth,
	output logic                                       moved,
	output logic [paik_pkg::JOINT_OUT_W-1:0]           active_joint,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [paik_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [paik_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import paik_pkg::*;

	localparam int AW = $clog2(ANGLE_STEPS);
	localparam int QN = ANGLE_STEPS / 4;
	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int KW = JW + 1;
	localparam int RW = ACC_W - ROUND_SHIFT;
	localparam int OUT_ANGLES = 4;

	localparam logic [JW-1:0]     LAST_JOINT = JW'(JOINTS - 1);
	localparam logic [KW-1:0]     K_FK_LAST  = KW'(2 * JOINTS - 1);
	localparam logic [KW-1:0]     K_DX       = KW'(0);
	localparam logic [KW-1:0]     K_DY       = KW'(1);
	localparam logic [KW-1:0]     K_SETTLE   = KW'(2);
	localparam logic [AW-1:0]     QN_ANG     = AW'(QN);
	localparam logic [AW-2:0]     QN_IDX     = (AW - 1)'(QN);
	localparam logic signed [RW-1:0] R_MAX   = RW'(TIP_MAX);
	localparam logic signed [RW-1:0] R_MIN   = RW'(TIP_MIN);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FK,
		ST_FK_DRAIN,
		ST_DIST,
		ST_DIST_DRAIN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PASS_BASE,
		PASS_PLUS,
		PASS_MINUS
	} pass_t;

	typedef enum logic [1:0] {
		OP_X,
		OP_Y,
		OP_DIST,
		OP_SETTLE
	} op_t;

	// Round Q14 sum to Q8 (half up) and saturate to the tip range.
	function automatic logic signed [TIP_W-1:0] round_tip(input logic signed [ACC_W-1:0] s);
		logic signed [ACC_W-1:0] b;
		logic signed [RW-1:0]    r;
		b = s + ACC_W'(ROUND_BIAS);
		r = RW'(b >>> ROUND_SHIFT);
		if (r > R_MAX) begin
			r = R_MAX;
		end else if (r < R_MIN) begin
			r = R_MIN;
		end
		return TIP_W'(r);
	endfunction

	// Control state.
	state_t              state_q;
	pass_t               pass_q;
	logic [KW-1:0]       k_q;
	logic [JW-1:0]       ptr_q;
	logic [AW-1:0]       angle_q [JOINTS];
	logic [LINK_W-1:0]   link_q [LINKS];
	logic [SETTLE_W-1:0] settle_q;
	logic                s1_valid_q;
	logic                s2_valid_q;
	logic                out_valid_q;
	logic signed [TIP_W-1:0]   tip_x_q;
	logic signed [TIP_W-1:0]   tip_y_q;
	logic [ANGLE_OUT_W-1:0]    out_angle_q [OUT_ANGLES];
	logic                      moved_q;
	logic [JOINT_OUT_W-1:0]    active_q;

	// Datapath.
	logic signed [TARGET_FP_W-1:0] tx_q;
	logic signed [TARGET_FP_W-1:0] ty_q;
	logic [AW-1:0]                 orig_q;
	op_t                           s1_op_q;
	logic signed [MUL_W-1:0]       s1_a_q;
	logic signed [MUL_W-1:0]       s1_b_q;
	op_t                           s2_op_q;
	logic signed [PROD_W-1:0]      s2_prod_q;
	logic signed [ACC_W-1:0]       acc_x_q;
	logic signed [ACC_W-1:0]       acc_y_q;
	logic signed [TIP_W-1:0]       cur_x_q;
	logic signed [TIP_W-1:0]       cur_y_q;
	logic [DIST_W-1:0]             dist_q;
	logic [DIST_W-1:0]             settle_sq_q;
	logic [DIST_W-1:0]             dist_plus_q;
	logic signed [TIP_W-1:0]       plus_x_q;
	logic signed [TIP_W-1:0]       plus_y_q;
	logic signed [TIP_W-1:0]       fin_x_q;
	logic signed [TIP_W-1:0]       fin_y_q;
	logic                          fin_moved_q;

	// Combinational.
	logic                    take;
	logic                    pipe_empty;
	logic                    out_free;
	logic                    decide;
	logic                    settled;
	logic                    pick_plus;
	logic [JW-1:0]           jnt;
	logic [JW+1:0]           jnt_ext;
	logic [AW-1:0]           ang_j;
	logic [LINK_W-1:0]       len_j;
	logic [KW-1:0]           k_dist_last;
	logic [AW-1:0]           look_ang;
	logic [1:0]              look_quad;
	logic [AW-2:0]           look_m;
	logic [AW-2:0]           look_idx;
	logic [MAG_W-1:0]        look_mag;
	logic signed [TRIG_W-1:0] look_trig;
	logic                    issue_valid;
	op_t                     issue_op;
	logic signed [MUL_W-1:0] issue_a;
	logic signed [MUL_W-1:0] issue_b;
	logic signed [MUL_W-1:0] dx;
	logic signed [MUL_W-1:0] dy;
	logic [MAG_W-1:0]        sine_tab [QN + 1];
	logic [ANGLE_OUT_W-1:0]  ang_view [OUT_ANGLES];

	// Quarter-wave sine table, built at elaboration.
	for (genvar g = 0; g <= QN; g++) begin : g_tab
		assign sine_tab[g] = quarter_sine(g, AW);
	end

	for (genvar g = 0; g < OUT_ANGLES; g++) begin : g_view
		if (g < JOINTS) begin : g_on
			assign ang_view[g] = ANGLE_OUT_W'(angle_q[g]);
		end else begin : g_off
			assign ang_view[g] = '0;
		end
	end

	assign take       = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign pipe_empty = !s1_valid_q && !s2_valid_q;
	assign out_free   = !out_valid_q || !out_stall;
	assign decide     = (state_q == ST_DIST_DRAIN) && pipe_empty;
	assign settled    = !(dist_q > settle_sq_q);
	assign pick_plus  = dist_plus_q < dist_q;
	assign cfg_ready  = 1'b1;

	assign jnt         = k_q[KW-1:1];
	assign jnt_ext     = (JW + 2)'(jnt);
	assign ang_j       = angle_q[jnt];
	assign len_j       = (int'(jnt) < LINKS) ? link_q[jnt_ext[1:0]] : '0;
	assign k_dist_last = (pass_q == PASS_BASE) ? K_SETTLE : K_DY;

	assign dx = MUL_W'(tx_q) - MUL_W'(cur_x_q);
	assign dy = MUL_W'(ty_q) - MUL_W'(cur_y_q);

	// Even k feeds cosine into x, odd k feeds sine into y.
	assign look_ang  = k_q[0] ? ang_j : ang_j + QN_ANG;
	assign look_quad = look_ang[AW-1 -: 2];
	assign look_m    = {1'b0, look_ang[AW-3:0]};
	assign look_idx  = look_quad[0] ? (QN_IDX - look_m) : look_m;
	assign look_mag  = sine_tab[look_idx];
	assign look_trig = look_quad[1] ? -signed'({1'b0, look_mag}) : signed'({1'b0, look_mag});

	always_comb begin
		issue_valid = 1'b0;
		issue_op    = OP_X;
		issue_a     = '0;
		issue_b     = '0;
		unique case (state_q)
			ST_FK: begin
				issue_valid = 1'b1;
				issue_op    = k_q[0] ? OP_Y : OP_X;
				issue_a     = MUL_W'(signed'({1'b0, len_j}));
				issue_b     = MUL_W'(look_trig);
			end
			ST_DIST: begin
				issue_valid = 1'b1;
				case (k_q)
					K_DX: begin
						issue_op = OP_DIST;
						issue_a  = dx;
						issue_b  = dx;
					end
					K_DY: begin
						issue_op = OP_DIST;
						issue_a  = dy;
						issue_b  = dy;
					end
					default: begin
						issue_op = OP_SETTLE;
						issue_a  = MUL_W'(signed'({1'b0, settle_q}));
						issue_b  = MUL_W'(signed'({1'b0, settle_q}));
					end
				endcase
			end
			default: begin
				issue_valid = 1'b0;
			end
		endcase
	end

	// Sequencer, architectural state, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= PASS_BASE;
			k_q         <= '0;
			ptr_q       <= LAST_JOINT;
			for (int i = 0; i < JOINTS; i++) begin
				angle_q[i] <= '0;
			end
			link_q[0]   <= LINK0_RST;
			link_q[1]   <= LINK1_RST;
			link_q[2]   <= LINK2_RST;
			link_q[3]   <= LINK3_RST;
			settle_q    <= SETTLE_RST;
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			tip_x_q     <= '0;
			tip_y_q     <= '0;
			for (int i = 0; i < OUT_ANGLES; i++) begin
				out_angle_q[i] <= '0;
			end
			moved_q     <= 1'b0;
			active_q    <= '0;
		end else begin
			s1_valid_q <= issue_valid;
			s2_valid_q <= s1_valid_q;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index) inside
					CFG_LINK0, CFG_LINK1, CFG_LINK2, CFG_LINK3: begin
						link_q[cfg_index[1:0]] <= cfg_data[LINK_W-1:0];
					end
					CFG_SETTLE: begin
						settle_q <= cfg_data[SETTLE_W-1:0];
					end
					default: begin
					end
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_FK;
						pass_q  <= PASS_BASE;
						k_q     <= '0;
						if (restart) begin
							ptr_q <= LAST_JOINT;
						end
					end
				end
				ST_FK: begin
					k_q <= k_q + 1'b1;
					if (k_q == K_FK_LAST) begin
						state_q <= ST_FK_DRAIN;
					end
				end
				ST_FK_DRAIN: begin
					if (pipe_empty) begin
						state_q <= ST_DIST;
						k_q     <= '0;
					end
				end
				ST_DIST: begin
					k_q <= k_q + 1'b1;
					if (k_q == k_dist_last) begin
						state_q <= ST_DIST_DRAIN;
					end
				end
				ST_DIST_DRAIN: begin
					if (pipe_empty) begin
						k_q <= '0;
						unique case (pass_q)
							PASS_BASE: begin
								if (settled) begin
									state_q <= ST_DONE;
								end else begin
									angle_q[ptr_q] <= orig_q + 1'b1;
									pass_q         <= PASS_PLUS;
									state_q        <= ST_FK;
								end
							end
							PASS_PLUS: begin
								angle_q[ptr_q] <= orig_q - 1'b1;
								pass_q         <= PASS_MINUS;
								state_q        <= ST_FK;
							end
							default: begin
								// The minus trial is already in place; a tie keeps it.
								if (pick_plus) begin
									angle_q[ptr_q] <= orig_q + 1'b1;
								end
								ptr_q   <= (ptr_q == '0) ? LAST_JOINT : ptr_q - 1'b1;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
				tip_x_q     <= fin_x_q;
				tip_y_q     <= fin_y_q;
				for (int i = 0; i < OUT_ANGLES; i++) begin
					out_angle_q[i] <= ang_view[i];
				end
				moved_q     <= fin_moved_q;
				active_q    <= JOINT_OUT_W'(ptr_q);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Multiplier pipeline and accumulators.
	always_ff @(posedge clk) begin
		if (take) begin
			tx_q <= signed'({target_x, FRAC_W'(0)});
			ty_q <= signed'({target_y, FRAC_W'(0)});
		end

		if ((state_q == ST_FK) && (pass_q == PASS_BASE) && (jnt == ptr_q)) begin
			orig_q <= ang_j;
		end

		s1_op_q   <= issue_op;
		s1_a_q    <= issue_a;
		s1_b_q    <= issue_b;
		s2_op_q   <= s1_op_q;
		s2_prod_q <= s1_a_q * s1_b_q;

		if (take || decide) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (s2_valid_q && (s2_op_q == OP_X)) begin
			acc_x_q <= acc_x_q + ACC_W'(s2_prod_q);
		end else if (s2_valid_q && (s2_op_q == OP_Y)) begin
			acc_y_q <= acc_y_q + ACC_W'(s2_prod_q);
		end

		if ((state_q == ST_FK_DRAIN) && pipe_empty) begin
			cur_x_q <= round_tip(acc_x_q);
			cur_y_q <= round_tip(acc_y_q);
			dist_q  <= '0;
		end else if (s2_valid_q && (s2_op_q == OP_DIST)) begin
			dist_q <= dist_q + DIST_W'(s2_prod_q);
		end

		if (s2_valid_q && (s2_op_q == OP_SETTLE)) begin
			settle_sq_q <= DIST_W'(s2_prod_q);
		end

		if (decide) begin
			case (pass_q)
				PASS_BASE: begin
					fin_x_q     <= cur_x_q;
					fin_y_q     <= cur_y_q;
					fin_moved_q <= 1'b0;
				end
				PASS_PLUS: begin
					dist_plus_q <= dist_q;
					plus_x_q    <= cur_x_q;
					plus_y_q    <= cur_y_q;
				end
				default: begin
					fin_x_q     <= pick_plus ? plus_x_q : cur_x_q;
					fin_y_q     <= pick_plus ? plus_y_q : cur_y_q;
					fin_moved_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign tip_x        = tip_x_q;
	assign tip_y        = tip_y_q;
	assign angle_first  = out_angle_q[0];
	assign angle_second = out_angle_q[1];
	assign angle_third  = out_angle_q[2];
	assign angle_fourth = out_angle_q[3];
	assign moved        = moved_q;
	assign active_joint = active_q;

endmodule
`default_nettype wire

// ===== hw/rtl/paik_checker.sv =====
// Port-level checks for the planar arm IK step core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module paik_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_stall,
	input wire logic                                 out_valid,
	input wire logic                                 out_stall,
	input wire logic signed [paik_pkg::TIP_W-1:0]    tip_x,
	input wire logic signed [paik_pkg::TIP_W-1:0]    tip_y,
	input wire logic [paik_pkg::ANGLE_OUT_W-1:0]     angle_first,
	input wire logic                                 moved,
	input wire logic [paik_pkg::JOINT_OUT_W-1:0]     active_joint
);

	// The block works on one tick at a time, so it is busy right after a transfer in.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted again right after a transfer");

	// A new result is only written while a tick is in progress.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a tick in progress");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(tip_x) && $stable(tip_y) &&
			$stable(angle_first) && $stable(moved) && $stable(active_joint)))
		else $error("stalled result changed");

endmodule

bind planar_arm_ik_coordinate_step_core paik_checker u_paik_checker (.*);
`default_nettype wire

// ===== sim/planar_arm_pose_checker.sv =====
// Checker that predicts every result of the planar arm IK step core and compares it.
`timescale 1ns / 1ps
module planar_arm_pose_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic signed [paik_pkg::TARGET_W-1:0]  target_x,
	input  logic signed [paik_pkg::TARGET_W-1:0]  target_y,
	input  logic                                  restart,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [paik_pkg::TIP_W-1:0]     tip_x,
	input  logic signed [paik_pkg::TIP_W-1:0]     tip_y,
	input  logic [paik_pkg::ANGLE_OUT_W-1:0]      angle_first,
	input  logic [paik_pkg::ANGLE_OUT_W-1:0]      angle_second,
	input  logic [paik_pkg::ANGLE_OUT_W-1:0]      angle_third,
	input  logic [paik_pkg::ANGLE_OUT_W-1:0]      angle_fourth,
	input  logic                                  moved,
	input  logic [paik_pkg::JOINT_OUT_W-1:0]      active_joint,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [paik_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [paik_pkg::CFG_DATA_W-1:0]       cfg_data,
	output int                                    mismatch_count,
	output int                                    poses_waiting
);
	import paik_pkg::*;

	// Odd sine polynomial over one quadrant, Q30.
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint SIN_K1  = 64'sd1686629713;
	localparam longint SIN_K3  = -64'sd693598669;
	localparam longint SIN_K5  = 64'sd85569306;
	localparam longint SIN_K7  = -64'sd5026995;
	localparam longint SIN_K9  = 64'sd172272;
	localparam longint SIN_K11 = -64'sd3864;
	localparam logic [JOINT_OUT_W-1:0] LAST_JOINT = JOINT_OUT_W'(JOINTS_DEF - 1);

	typedef logic [LINKS-1:0][ANGLE_OUT_W-1:0] angle_set_t;

	typedef struct packed {
		int x;
		int y;
	} tip_t;

	typedef struct packed {
		logic [TIP_W-1:0]       tip_x;
		logic [TIP_W-1:0]       tip_y;
		angle_set_t             angle;
		logic                   moved;
		logic [JOINT_OUT_W-1:0] active_joint;
	} pose_t;

	angle_set_t                  joint_angle;
	logic [JOINT_OUT_W-1:0]      next_joint;
	logic [LINKS-1:0][LINK_W-1:0] link_len;
	logic [SETTLE_W-1:0]         settle;
	pose_t                       expected_poses[$];
	int                          errors;

	// Q14 sine of a 32-bit turn fraction.
	function automatic int q14_sine(input logic [31:0] phase);
		longint t;
		longint t2;
		longint acc;
		longint v;
		longint mag;
		t = longint'(phase[29:0]);
		if (phase[30]) begin
			t = ONE_Q30 - t;
		end
		t2  = (t * t) / ONE_Q30;
		acc = SIN_K11;
		acc = SIN_K9 + (acc * t2) / ONE_Q30;
		acc = SIN_K7 + (acc * t2) / ONE_Q30;
		acc = SIN_K5 + (acc * t2) / ONE_Q30;
		acc = SIN_K3 + (acc * t2) / ONE_Q30;
		acc = SIN_K1 + (acc * t2) / ONE_Q30;
		v   = (acc * t) / ONE_Q30;
		mag = (v > 0) ? (v + 64'sd32768) / 64'sd65536 : 64'sd0;
		if (mag > 64'sd16384) begin
			mag = 64'sd16384;
		end
		return phase[31] ? -int'(mag) : int'(mag);
	endfunction

	// Q14 sum down to Q8 with round half up, then clamp to the tip range.
	function automatic int q8_of(input int s);
		int r;
		r = (s + 32) >>> 6;
		if (r > TIP_MAX) begin
			r = TIP_MAX;
		end
		if (r < TIP_MIN) begin
			r = TIP_MIN;
		end
		return r;
	endfunction

	function automatic tip_t tip_of(input angle_set_t a);
		int          sx;
		int          sy;
		int          len;
		int          i;
		logic [31:0] turn;
		tip_t        r;
		sx = 0;
		sy = 0;
		for (i = 0; i < LINKS; i++) begin
			len  = int'(link_len[i]);
			turn = {a[i], 23'd0};
			sx += len * q14_sine(turn + 32'h4000_0000);
			sy += len * q14_sine(turn);
		end
		r.x = q8_of(sx);
		r.y = q8_of(sy);
		return r;
	endfunction

	function automatic longint gap_sq(input angle_set_t a, input longint tx, input longint ty);
		tip_t   p;
		longint dx;
		longint dy;
		p  = tip_of(a);
		dx = tx - longint'(p.x);
		dy = ty - longint'(p.y);
		return dx * dx + dy * dy;
	endfunction

	// One coordinate descent tick; updates the predicted arm state.
	function automatic pose_t predict_pose(input logic signed [TARGET_W-1:0] gx,
			input logic signed [TARGET_W-1:0] gy, input logic back_to_last);
		longint                 tx;
		longint                 ty;
		longint                 dp;
		longint                 dm;
		angle_set_t             trial;
		logic [JOINT_OUT_W-1:0] p;
		logic [ANGLE_OUT_W-1:0] plus_a;
		logic [ANGLE_OUT_W-1:0] minus_a;
		logic                   did_move;
		tip_t                   tip;
		pose_t                  r;
		tx = longint'(gx) * 256;
		ty = longint'(gy) * 256;
		did_move = 1'b0;
		if (back_to_last) begin
			next_joint = LAST_JOINT;
		end
		if (gap_sq(joint_angle, tx, ty) > longint'(settle) * longint'(settle)) begin
			p       = next_joint;
			plus_a  = joint_angle[p] + 1'b1;
			minus_a = joint_angle[p] - 1'b1;
			trial    = joint_angle;
			trial[p] = plus_a;
			dp       = gap_sq(trial, tx, ty);
			trial[p] = minus_a;
			dm       = gap_sq(trial, tx, ty);
			joint_angle[p] = (dp < dm) ? plus_a : minus_a;
			next_joint = (p == '0) ? LAST_JOINT : p - 1'b1;
			did_move = 1'b1;
		end
		tip = tip_of(joint_angle);
		r.tip_x        = tip.x[TIP_W-1:0];
		r.tip_y        = tip.y[TIP_W-1:0];
		r.angle        = joint_angle;
		r.moved        = did_move;
		r.active_joint = next_joint;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("checker: mismatch: %s", what);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [TIP_W-1:0] got_v,
			input logic [TIP_W-1:0] want_v);
		if (got_v !== want_v) begin
			report_mismatch($sformatf("%s got %0h expected %0h", name, got_v, want_v));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pose_t want;
		if (!arst_n) begin
			joint_angle = '0;
			next_joint  = LAST_JOINT;
			link_len    = {LINK3_RST, LINK2_RST, LINK1_RST, LINK0_RST};
			settle      = SETTLE_RST;
			expected_poses.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LINK0:  link_len[0] = cfg_data[LINK_W-1:0];
					CFG_LINK1:  link_len[1] = cfg_data[LINK_W-1:0];
					CFG_LINK2:  link_len[2] = cfg_data[LINK_W-1:0];
					CFG_LINK3:  link_len[3] = cfg_data[LINK_W-1:0];
					CFG_SETTLE: settle = cfg_data[SETTLE_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_poses.size() == 0) begin
					report_mismatch($sformatf("result transfer with no pose pending, tip %0h,%0h",
						tip_x, tip_y));
				end else begin
					want = expected_poses.pop_front();
					check_field("tip_x", tip_x, want.tip_x);
					check_field("tip_y", tip_y, want.tip_y);
					check_field("angle_first", angle_first, want.angle[0]);
					check_field("angle_second", angle_second, want.angle[1]);
					check_field("angle_third", angle_third, want.angle[2]);
					check_field("angle_fourth", angle_fourth, want.angle[3]);
					check_field("moved", moved, want.moved);
					check_field("active_joint", active_joint, want.active_joint);
				end
			end
			if (in_valid && !in_stall) begin
				expected_poses.push_back(predict_pose(target_x, target_y, restart));
			end
		end
		mismatch_count <= errors;
		poses_waiting  <= expected_poses.size();
	end

endmodule

// ===== sim/planar_arm_ik_coordinate_step_core_test.sv =====
// Testbench top: stimulus, register setup and verdict for the planar arm IK step core.
`timescale 1ns / 1ps
module planar_arm_ik_coordinate_step_core_test;
	import paik_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	logic signed [TARGET_W-1:0]  target_x  = '0;
	logic signed [TARGET_W-1:0]  target_y  = '0;
	logic                        restart   = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [TIP_W-1:0]     tip_x;
	logic signed [TIP_W-1:0]     tip_y;
	logic [ANGLE_OUT_W-1:0]      angle_first;
	logic [ANGLE_OUT_W-1:0]      angle_second;
	logic [ANGLE_OUT_W-1:0]      angle_third;
	logic [ANGLE_OUT_W-1:0]      angle_fourth;
	logic                        moved;
	logic [JOINT_OUT_W-1:0]      active_joint;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data  = '0;

	int   mismatch_count;
	int   poses_waiting;
	logic idling_on   = 1'b1;
	int   stall_left  = 0;
	int   cycle_count = 0;
	int   reach_px    = 0;

	planar_arm_ik_coordinate_step_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.target_x     (target_x),
		.target_y     (target_y),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.tip_x        (tip_x),
		.tip_y        (tip_y),
		.angle_first  (angle_first),
		.angle_second (angle_second),
		.angle_third  (angle_third),
		.angle_fourth (angle_fourth),
		.moved        (moved),
		.active_joint (active_joint),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	planar_arm_pose_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.target_x       (target_x),
		.target_y       (target_y),
		.restart        (restart),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tip_x          (tip_x),
		.tip_y          (tip_y),
		.angle_first    (angle_first),
		.angle_second   (angle_second),
		.angle_third    (angle_third),
		.angle_fourth   (angle_fourth),
		.moved          (moved),
		.active_joint   (active_joint),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.poses_waiting  (poses_waiting)
	);

	always #5 clk = ~clk;

	// Receiver back-pressure in random bursts, only while idling_on is set.
	always @(posedge clk) begin
		if (!idling_on) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Valid stays high across back-to-back transfers so it is never dropped and raised in one step.
	task automatic send_tick(input logic [TARGET_W-1:0] x, input logic [TARGET_W-1:0] y,
			input logic r);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		target_x <= x;
		target_y <= y;
		restart  <= r;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		do @(posedge clk); while (poses_waiting != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_arm(input logic [CFG_DATA_W-1:0] l0, input logic [CFG_DATA_W-1:0] l1,
			input logic [CFG_DATA_W-1:0] l2, input logic [CFG_DATA_W-1:0] l3,
			input logic [CFG_DATA_W-1:0] s);
		write_register(CFG_LINK0, l0);
		write_register(CFG_LINK1, l1);
		// An index past the last register must leave everything alone.
		write_register(CFG_IDX_W'(CFG_SETTLE + CFG_IDX_W'($urandom_range(1, 3))),
			CFG_DATA_W'($urandom));
		write_register(CFG_LINK2, l2);
		write_register(CFG_LINK3, l3);
		write_register(CFG_SETTLE, s);
		cfg_valid <= 1'b0;
		reach_px = int'(l0[LINK_W-1:0]) + int'(l1[LINK_W-1:0]) + int'(l2[LINK_W-1:0])
			+ int'(l3[LINK_W-1:0]);
		@(posedge clk);
	endtask

	// Mostly held targets near the arm's reach so the arm converges and settles; some noise ticks.
	task automatic run_random(input int ticks, input logic allow_idle);
		int                  sent;
		int                  hold;
		int                  span;
		int                  k;
		logic [TARGET_W-1:0] gx;
		logic [TARGET_W-1:0] gy;
		sent = 0;
		while (sent < ticks) begin
			idling_on <= allow_idle && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) != 0) begin
				span = reach_px + 2;
				gx   = TARGET_W'(int'($urandom_range(0, 2 * span)) - span);
				gy   = TARGET_W'(int'($urandom_range(0, 2 * span)) - span);
				hold = $urandom_range(4, 60);
				for (k = 0; k < hold; k++) begin
					send_tick(gx, gy, (k == 0) ? 1'($urandom_range(0, 1))
						: ($urandom_range(0, 15) == 0));
				end
			end else begin
				hold = $urandom_range(1, 3);
				for (k = 0; k < hold; k++) begin
					send_tick(TARGET_W'($urandom), TARGET_W'($urandom), 1'($urandom));
				end
			end
			sent += hold;
			if ($urandom_range(0, 19) == 0) begin
				wait_results_done();
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		reach_px = int'(LINK0_RST) + int'(LINK1_RST) + int'(LINK2_RST) + int'(LINK3_RST);

		// After reset the tip sits at (165, 0); the first three ticks are within the settle radius,
		// the third exactly on it.
		send_tick(12'd165, 12'd0, 1'b0);
		send_tick(12'd165, 12'd1, 1'b0);
		send_tick(12'd165, 12'd2, 1'b0);
		send_tick(12'd165, 12'd3, 1'b0);
		// Target below the arm drives the minus step through the wrap at zero.
		send_tick(-12'sd165, -12'sd165, 1'b1);
		send_tick(-12'sd165, -12'sd165, 1'b0);
		send_tick(-12'sd165, -12'sd165, 1'b0);
		send_tick(-12'sd165, -12'sd165, 1'b0);
		send_tick(-12'sd165, -12'sd165, 1'b0);
		send_tick(12'h7FF, 12'h7FF, 1'b0);
		send_tick(12'h800, 12'h800, 1'b1);
		send_tick(12'h7FF, 12'h800, 1'b0);
		send_tick(12'h800, 12'h7FF, 1'b1);
		send_tick(12'h000, 12'h000, 1'b1);
		run_random(80, 1'b1);

		// Zero links: the tip never moves, so any nonzero gap is a tie and minus wins.
		wait_results_done();
		program_arm(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_tick(12'd0, 12'd0, 1'b0);
		send_tick(12'd1, 12'd0, 1'b0);
		send_tick(12'h800, 12'h7FF, 1'b1);
		send_tick(12'h7FF, 12'h800, 1'b0);
		run_random(80, 1'b1);

		// Full-scale links and radius; upper data bits must be masked off the link registers.
		wait_results_done();
		program_arm(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_tick(12'h7FF, 12'h7FF, 1'b1);
		send_tick(12'h800, 12'h800, 1'b0);
		run_random(80, 1'b1);

		repeat (3) begin
			wait_results_done();
			program_arm(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
				CFG_DATA_W'($urandom), $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(0, 1023))
				: CFG_DATA_W'($urandom));
			run_random(80, 1'b1);
		end

		wait_results_done();
		program_arm({8'd0, LINK0_RST}, {8'd0, LINK1_RST}, {8'd0, LINK2_RST}, {8'd0, LINK3_RST},
			CFG_DATA_W'($urandom_range(0, 4095)));
		run_random(80, 1'b0);

		wait_results_done();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && poses_waiting == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
